/* rtl/otwc_pkg.sv */
package otwc_pkg;

    localparam int COORD_BITS     = 16;
    localparam int WINDOW_BITS    = 8;
    localparam int HALF_BITS      = WINDOW_BITS - 1;
    localparam int FINAL_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * COORD_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COORD_BITS;
    localparam int STATUS_BITS    = 2;
    localparam int PAD_BITS       = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_HEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RANGE   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_AZIMUTH = 3'd5;

    localparam logic [COORD_BITS-1:0]  RESET_BAND_WIDTH     = 16'd1024;
    localparam logic [COORD_BITS-1:0]  RESET_BAND_HEIGHT    = 16'd1024;
    localparam logic [COORD_BITS-1:0]  RESET_TILE_WIDTH     = 16'd256;
    localparam logic [COORD_BITS-1:0]  RESET_TILE_HEIGHT    = 16'd256;
    localparam logic [WINDOW_BITS-1:0] RESET_WINDOW_RANGE   = 8'd15;
    localparam logic [WINDOW_BITS-1:0] RESET_WINDOW_AZIMUTH = 8'd5;

    localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_WINDOW_BIG = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_INDEX_OOR  = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] column_index;
        logic [COORD_BITS-1:0] row_index;
    } tile_req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  src_x_first;
        logic [FINAL_BITS-1:0]  src_x_final;
        logic [COORD_BITS-1:0]  src_y_first;
        logic [FINAL_BITS-1:0]  src_y_final;
        logic [COORD_BITS-1:0]  dst_x_first;
        logic [COORD_BITS-1:0]  dst_x_final;
        logic [COORD_BITS-1:0]  dst_y_first;
        logic [COORD_BITS-1:0]  dst_y_final;
        logic [PAD_BITS-1:0]    pad_mask;
        logic [HALF_BITS-1:0]   half_window_x;
        logic [HALF_BITS-1:0]   half_window_y;
        logic [STATUS_BITS-1:0] status;
    } tile_win_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_src;
        logic [FINAL_BITS-1:0] final_src;
        logic [COORD_BITS-1:0] first_dst;
        logic [COORD_BITS-1:0] final_dst;
        logic                  pad_lo;
        logic                  pad_hi;
    } axis_win_t;

endpackage

/* rtl/overlapped_tile_window_calc.sv */
// Tile window calculator: a request (column_index, row_index) is taken at every
// clock edge with start high and busy low; busy never rises, so one request can
// be issued every cycle. Each result passes, in request order, through the input
// register, the product register (the tile-size multipliers) and the result
// register, and is flagged by a one-cycle done pulse. There is no flow control
// on the result side, so the receiver must capture every done pulse.
// Change configuration only while no request is in flight.
module overlapped_tile_window_calc (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [otwc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [otwc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  otwc_pkg::tile_req_t                   request,
    output logic                                  done,
    output otwc_pkg::tile_win_t                   result
);

    localparam int CB = otwc_pkg::COORD_BITS;
    localparam int WB = otwc_pkg::WINDOW_BITS;
    localparam int HB = otwc_pkg::HALF_BITS;
    localparam int PB = otwc_pkg::PROD_BITS;

    function automatic otwc_pkg::axis_win_t axis_calc(
        input logic [PB-1:0] prod,
        input logic [CB-1:0] band,
        input logic [CB-1:0] tile,
        input logic [HB-1:0] half
    );
        otwc_pkg::axis_win_t a;
        logic [PB:0]   sum_end;
        logic [PB:0]   end_m1;
        logic [PB:0]   end_halo;
        logic [PB-1:0] first_halo;
        logic [CB-1:0] band_m1;
        logic          last;
        logic          whole;
        sum_end    = {1'b0, prod} + (PB+1)'(tile);
        end_m1     = sum_end - (PB+1)'(1);
        end_halo   = end_m1 + (PB+1)'(half);
        first_halo = prod - PB'(half);
        band_m1    = band - CB'(1);
        // last tile: its nominal end reaches the band edge
        last       = (sum_end >= (PB+1)'(band));
        whole      = (tile >= band);
        a.first_dst = prod[CB-1:0];
        a.final_dst = last ? band_m1 : end_m1[CB-1:0];
        a.pad_lo    = whole || (prod == '0);
        a.pad_hi    = whole || last;
        a.first_src = a.pad_lo ? '0 : first_halo[CB-1:0];
        a.final_src = a.pad_hi ? {1'b0, band_m1} : end_halo[CB:0];
        return a;
    endfunction

    // configuration
    logic [CB-1:0] band_width_reg, band_height_reg, tile_width_reg, tile_height_reg;
    logic [WB-1:0] window_range_reg, window_azimuth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_width_reg     <= otwc_pkg::RESET_BAND_WIDTH;
            band_height_reg    <= otwc_pkg::RESET_BAND_HEIGHT;
            tile_width_reg     <= otwc_pkg::RESET_TILE_WIDTH;
            tile_height_reg    <= otwc_pkg::RESET_TILE_HEIGHT;
            window_range_reg   <= otwc_pkg::RESET_WINDOW_RANGE;
            window_azimuth_reg <= otwc_pkg::RESET_WINDOW_AZIMUTH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                otwc_pkg::REG_BAND_WIDTH:     band_width_reg     <= cfg_data[CB-1:0];
                otwc_pkg::REG_BAND_HEIGHT:    band_height_reg    <= cfg_data[CB-1:0];
                otwc_pkg::REG_TILE_WIDTH:     tile_width_reg     <= cfg_data[CB-1:0];
                otwc_pkg::REG_TILE_HEIGHT:    tile_height_reg    <= cfg_data[CB-1:0];
                otwc_pkg::REG_WINDOW_RANGE:   window_range_reg   <= cfg_data[WB-1:0];
                otwc_pkg::REG_WINDOW_AZIMUTH: window_azimuth_reg <= cfg_data[WB-1:0];
                default: ;
            endcase
        end
    end

    // derived configuration terms
    logic [CB-1:0] tile_w_eff, tile_h_eff;
    logic [WB-1:0] win_x_m1, win_y_m1;
    logic [HB-1:0] half_x, half_y;
    logic          window_big;

    always_comb
    begin
        tile_w_eff = (tile_width_reg == '0)  ? CB'(1) : tile_width_reg;
        tile_h_eff = (tile_height_reg == '0) ? CB'(1) : tile_height_reg;
        win_x_m1   = window_range_reg - WB'(1);
        win_y_m1   = window_azimuth_reg - WB'(1);
        half_x     = (window_range_reg == '0)   ? '0 : win_x_m1[WB-1:1];
        half_y     = (window_azimuth_reg == '0) ? '0 : win_y_m1[WB-1:1];
        window_big = (CB'({half_x, 1'b0}) > tile_w_eff) ||
                     (CB'({half_y, 1'b0}) > tile_h_eff);
    end

    // input register
    otwc_pkg::tile_req_t req_reg;
    logic                req_valid_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= request;
    end

    // product register: tile start coordinates
    logic [PB-1:0] prod_x_reg, prod_y_reg;
    logic [PB-1:0] prod_x_next, prod_y_next;
    logic          prod_valid_reg;

    assign prod_x_next = PB'(req_reg.column_index) * PB'(tile_w_eff);
    assign prod_y_next = PB'(req_reg.row_index) * PB'(tile_h_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    // result register
    otwc_pkg::axis_win_t ax, ay;
    otwc_pkg::tile_win_t result_reg, result_next;
    logic                done_reg;
    logic                in_range;

    always_comb
    begin
        ax = axis_calc(prod_x_reg, band_width_reg, tile_w_eff, half_x);
        ay = axis_calc(prod_y_reg, band_height_reg, tile_h_eff, half_y);
        // index < ceil(band / tile) is the same as index * tile < band
        in_range = (prod_x_reg < PB'(band_width_reg)) &&
                   (prod_y_reg < PB'(band_height_reg));

        result_next = '0;
        result_next.half_window_x = half_x;
        result_next.half_window_y = half_y;
        if (window_big)
            result_next.status = otwc_pkg::STATUS_WINDOW_BIG;
        else if (!in_range)
            result_next.status = otwc_pkg::STATUS_INDEX_OOR;
        else
        begin
            result_next.status      = otwc_pkg::STATUS_OK;
            result_next.src_x_first = ax.first_src;
            result_next.src_x_final = ax.final_src;
            result_next.src_y_first = ay.first_src;
            result_next.src_y_final = ay.final_src;
            result_next.dst_x_first = ax.first_dst;
            result_next.dst_x_final = ax.final_dst;
            result_next.dst_y_first = ay.first_dst;
            result_next.dst_y_final = ay.final_dst;
            result_next.pad_mask    = {ay.pad_hi, ay.pad_lo, ax.pad_hi, ax.pad_lo};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= prod_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every request transfer is followed by a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("request transfer not followed by a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(start, 3))
        else $error("result without a request");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != otwc_pkg::STATUS_OK) |->
        (result.pad_mask == '0 && result.dst_x_final == '0 &&
         result.src_x_final == '0 && result.src_y_final == '0))
        else $error("error result carries window data");

    a_dst_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == otwc_pkg::STATUS_OK) |->
        (result.dst_x_first <= result.dst_x_final &&
         result.dst_y_first <= result.dst_y_final))
        else $error("output window reversed");

    a_left_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == otwc_pkg::STATUS_OK) |->
        (result.pad_mask[0] == (result.dst_x_first == '0) &&
         result.src_x_first <= result.dst_x_first))
        else $error("left padding does not match first column");

endmodule

/* tb/testbench.sv */
module testbench;

    localparam int CB = otwc_pkg::COORD_BITS;
    localparam int WB = otwc_pkg::WINDOW_BITS;
    localparam int HB = otwc_pkg::HALF_BITS;
    localparam int FB = otwc_pkg::FINAL_BITS;
    localparam int IB = otwc_pkg::CFG_INDEX_BITS;
    localparam int DB = otwc_pkg::CFG_DATA_BITS;

    localparam logic [IB-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IB-1:0] REG_SPARE_B = 3'd7;
    localparam int PIPE_SLACK   = 8;
    localparam int TARGET_ITEMS = 1550;

    class window_checker;
        bit [CB-1:0] band_w, band_h, tile_w, tile_h;
        bit [WB-1:0] win_rng, win_az;
        otwc_pkg::tile_win_t expected_windows[$];
        int errors;
        int n_status[4];

        function new();
            band_w  = otwc_pkg::RESET_BAND_WIDTH;
            band_h  = otwc_pkg::RESET_BAND_HEIGHT;
            tile_w  = otwc_pkg::RESET_TILE_WIDTH;
            tile_h  = otwc_pkg::RESET_TILE_HEIGHT;
            win_rng = otwc_pkg::RESET_WINDOW_RANGE;
            win_az  = otwc_pkg::RESET_WINDOW_AZIMUTH;
        endfunction

        function void write_reg(logic [IB-1:0] idx, logic [DB-1:0] data);
            case (idx)
                otwc_pkg::REG_BAND_WIDTH:     band_w  = data;
                otwc_pkg::REG_BAND_HEIGHT:    band_h  = data;
                otwc_pkg::REG_TILE_WIDTH:     tile_w  = data;
                otwc_pkg::REG_TILE_HEIGHT:    tile_h  = data;
                otwc_pkg::REG_WINDOW_RANGE:   win_rng = data[WB-1:0];
                otwc_pkg::REG_WINDOW_AZIMUTH: win_az  = data[WB-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned eff_tile(longint unsigned t);
            return (t == 0) ? 1 : t;
        endfunction

        function longint unsigned half_win(longint unsigned w);
            return (w == 0) ? 0 : (w - 1) / 2;
        endfunction

        function longint unsigned tiles_x();
            return (band_w + eff_tile(tile_w) - 1) / eff_tile(tile_w);
        endfunction

        function longint unsigned tiles_y();
            return (band_h + eff_tile(tile_h) - 1) / eff_tile(tile_h);
        endfunction

        function otwc_pkg::axis_win_t axis_window(longint unsigned idx,
                                                  longint unsigned band,
                                                  longint unsigned tile,
                                                  longint unsigned half,
                                                  longint unsigned count);
            otwc_pkg::axis_win_t a;
            bit last;
            a = '0;
            last = (idx == count - 1);
            a.first_dst = CB'(tile * idx);
            a.final_dst = last ? CB'(band - 1) : CB'(tile * idx + tile - 1);
            if (tile >= band)
            begin
                a.pad_lo    = 1'b1;
                a.pad_hi    = 1'b1;
                a.first_src = '0;
                a.final_src = FB'(band - 1);
                return a;
            end
            if (idx == 0)
            begin
                a.pad_lo    = 1'b1;
                a.first_src = '0;
            end
            else
            begin
                a.first_src = CB'(tile * idx - half);
            end
            if (last)
            begin
                a.pad_hi    = 1'b1;
                a.final_src = FB'(band - 1);
            end
            else
            begin
                a.final_src = FB'(tile * (idx + 1) - 1 + half);
            end
            return a;
        endfunction

        function void note_request(otwc_pkg::tile_req_t req);
            otwc_pkg::tile_win_t w;
            otwc_pkg::axis_win_t ax, ay;
            longint unsigned tw, th, hx, hy, nx, ny;
            tw = eff_tile(tile_w);
            th = eff_tile(tile_h);
            hx = half_win(win_rng);
            hy = half_win(win_az);
            nx = tiles_x();
            ny = tiles_y();
            w = '0;
            // window check has priority over the index range check
            if (2 * hx > tw || 2 * hy > th)
                w.status = otwc_pkg::STATUS_WINDOW_BIG;
            else if (req.column_index >= nx || req.row_index >= ny)
                w.status = otwc_pkg::STATUS_INDEX_OOR;
            else
                w.status = otwc_pkg::STATUS_OK;
            if (w.status == otwc_pkg::STATUS_OK)
            begin
                ax = axis_window(req.column_index, band_w, tw, hx, nx);
                ay = axis_window(req.row_index, band_h, th, hy, ny);
                w.src_x_first = ax.first_src;
                w.src_x_final = ax.final_src;
                w.src_y_first = ay.first_src;
                w.src_y_final = ay.final_src;
                w.dst_x_first = ax.first_dst;
                w.dst_x_final = ax.final_dst;
                w.dst_y_first = ay.first_dst;
                w.dst_y_final = ay.final_dst;
                w.pad_mask    = {ay.pad_hi, ay.pad_lo, ax.pad_hi, ax.pad_lo};
            end
            w.half_window_x = HB'(hx);
            w.half_window_y = HB'(hy);
            n_status[w.status]++;
            expected_windows.push_back(w);
        endfunction

        function void cmp(string field, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_window(otwc_pkg::tile_win_t got);
            otwc_pkg::tile_win_t want;
            if (expected_windows.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_windows.pop_front();
            cmp("src_x_first",   want.src_x_first,   got.src_x_first);
            cmp("src_x_final",   want.src_x_final,   got.src_x_final);
            cmp("src_y_first",   want.src_y_first,   got.src_y_first);
            cmp("src_y_final",   want.src_y_final,   got.src_y_final);
            cmp("dst_x_first",   want.dst_x_first,   got.dst_x_first);
            cmp("dst_x_final",   want.dst_x_final,   got.dst_x_final);
            cmp("dst_y_first",   want.dst_y_first,   got.dst_y_first);
            cmp("dst_y_final",   want.dst_y_final,   got.dst_y_final);
            cmp("pad_mask",      want.pad_mask,      got.pad_mask);
            cmp("half_window_x", want.half_window_x, got.half_window_x);
            cmp("half_window_y", want.half_window_y, got.half_window_y);
            cmp("status",        want.status,        got.status);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [IB-1:0]       cfg_index;
    logic [DB-1:0]       cfg_data;
    logic                start;
    logic                busy;
    otwc_pkg::tile_req_t request;
    logic                done;
    otwc_pkg::tile_win_t result;

    window_checker chk;
    int burst_left;
    int sent;
    int settings;

    overlapped_tile_window_calc u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            chk.check_window(result);
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    task write_reg(input logic [IB-1:0] idx, input logic [DB-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        chk.write_reg(idx, data);
    endtask

    task load_config(input bit [15:0] bw, input bit [15:0] bh, input bit [15:0] tw,
                     input bit [15:0] th, input bit [7:0] wr, input bit [7:0] wa);
        // unmapped indexes and the unused upper bits of the window registers get junk
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
        write_reg(otwc_pkg::REG_BAND_WIDTH, bw);
        write_reg(otwc_pkg::REG_BAND_HEIGHT, bh);
        write_reg(otwc_pkg::REG_TILE_WIDTH, tw);
        write_reg(otwc_pkg::REG_TILE_HEIGHT, th);
        write_reg(otwc_pkg::REG_WINDOW_RANGE, {8'($urandom), wr});
        write_reg(otwc_pkg::REG_WINDOW_AZIMUTH, {8'($urandom), wa});
        @(negedge clk);
        cfg_write = 1'b0;
        settings++;
    endtask

    // sender pause: hold off until every expected window has come back
    task wait_idle();
        @(negedge clk);
        start = 1'b0;
        burst_left = 0;
        while (chk.expected_windows.size() != 0)
            @(negedge clk);
        repeat (PIPE_SLACK) @(negedge clk);
    endtask

    task send_tile(input bit [15:0] col, input bit [15:0] row);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        start = 1'b1;
        request.column_index = col;
        request.row_index    = row;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        chk.note_request(request);
        burst_left--;
        sent++;
    endtask

    function bit [15:0] pick_index(longint unsigned count);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0 || count == 0)
            return 16'($urandom);
        if (r == 1)
            return 16'($urandom_range(count, 65535));
        if (r == 2)
            return 16'd0;
        if (r == 3)
            return 16'(count - 1);
        return 16'($urandom_range(0, count - 1));
    endfunction

    function int unsigned pick_band();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1, 16);
            1, 2, 3: return $urandom_range(17, 1024);
            4, 5:    return $urandom_range(1025, 65535);
            6:       return 65535;
            7:       return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            default: return $urandom_range(100, 5000);
        endcase
    endfunction

    function int unsigned pick_tile(int unsigned band);
        int unsigned b, t;
        b = (band == 0) ? 100 : band;
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       t = b + $urandom_range(0, 50);
            2:       return 65535;
            3:       return $urandom_range(1, 65535);
            default: t = b / $urandom_range(1, 24) + $urandom_range(0, 3);
        endcase
        if (t == 0)
            t = 1;
        return (t > 65535) ? 65535 : t;
    endfunction

    function int unsigned pick_window(int unsigned tile);
        int unsigned t;
        t = (tile == 0) ? 1 : tile;
        // mostly a window that fits the tile, sometimes anything
        if ($urandom_range(0, 7) == 0 || t >= 254)
            return $urandom_range(0, 255);
        return $urandom_range(0, t + 1);
    endfunction

    task random_config();
        int unsigned bw, bh, tw, th, wr, wa;
        bw = pick_band();
        bh = pick_band();
        tw = pick_tile(bw);
        th = pick_tile(bh);
        wr = pick_window(tw);
        wa = pick_window(th);
        load_config(16'(bw), 16'(bh), 16'(tw), 16'(th), 8'(wr), 8'(wa));
    endtask

    initial
    begin
        int n, pause_at;
        bit pressure_done;
        chk = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        request = '0;
        burst_left = 0;
        sent = 0;
        settings = 0;
        pressure_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: first, interior, last tiles and indexes past the end
        send_tile(0, 0);
        send_tile(1, 2);
        send_tile(3, 3);
        send_tile(4, 0);
        send_tile(0, 4);
        send_tile(65535, 65535);
        send_tile(3, 1);
        wait_idle();

        // window too large wins over a bad index
        load_config(1000, 1000, 10, 300, 255, 3);
        send_tile(0, 0);
        send_tile(65535, 0);
        wait_idle();

        // zero band gives no tiles; zero tile size acts as one
        load_config(0, 5, 0, 0, 2, 1);
        send_tile(0, 0);
        wait_idle();
        load_config(65535, 65535, 0, 65535, 1, 255);
        send_tile(65534, 0);
        send_tile(65535, 0);
        send_tile(1, 0);
        wait_idle();

        // source window past 16 bits on a non-last tile
        load_config(65535, 1, 65534, 1, 255, 0);
        send_tile(0, 0);
        send_tile(1, 0);
        send_tile(2, 0);
        wait_idle();

        load_config(1, 1, 1, 1, 1, 1);
        send_tile(0, 0);
        send_tile(0, 1);
        wait_idle();
        load_config(65535, 65535, 65535, 65535, 255, 255);
        send_tile(0, 0);
        send_tile(65535, 65535);
        wait_idle();

        while (sent < TARGET_ITEMS)
        begin
            random_config();
            n = $urandom_range(20, 80);
            pause_at = (!pressure_done || $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                begin
                    wait_idle();
                    pressure_done = 1'b1;
                end
                send_tile(pick_index(chk.tiles_x()), pick_index(chk.tiles_y()));
            end
            wait_idle();
        end

        $display("Covered %0d tile requests over %0d register settings", sent, settings);
        $display("Status counts: ok %0d, window too large %0d, index out of range %0d",
                 chk.n_status[otwc_pkg::STATUS_OK], chk.n_status[otwc_pkg::STATUS_WINDOW_BIG],
                 chk.n_status[otwc_pkg::STATUS_INDEX_OOR]);
        if (chk.errors == 0 && chk.expected_windows.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
